/* rtl/four_level_priority_dispatcher_defines.svh */
// assertion macros for the four level priority dispatcher
`ifndef FOUR_LEVEL_PRIORITY_DISPATCHER_DEFINES_SVH
`define FOUR_LEVEL_PRIORITY_DISPATCHER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define FPD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("fpd check failed");

// next-cycle implication, sampled on clock, off during reset
`define FPD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("fpd check failed");

`endif

/* rtl/fpd_pkg.sv */
// types and constants shared by the priority dispatcher
package fpd_pkg;

   localparam int ID_W      = 8;
   localparam int TIME_W    = 16;
   localparam int PRI_W     = 3;
   localparam int OUT_LVL_W = 2;

   localparam logic MODE_SUBMIT = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] arrival_time;
      logic [PRI_W-1:0]  priority_level;
   } req_type;

   typedef struct packed {
      logic                 submit_rejected;
      logic                 dispatched;
      logic [ID_W-1:0]      out_job_id;
      logic [OUT_LVL_W-1:0] out_level;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] arrival_time;
      logic [PRI_W-1:0]  priority_level;
   } pend_entry_type;

   typedef struct packed {
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] arrival_time;
   } lvl_entry_type;

endpackage

/* rtl/fpd_ram.sv */
// generic simple dual port ram with registered read
module fpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/four_level_priority_dispatcher.sv */
// four level priority dispatcher: pending fifo, level fifos and tick sequencer
// submit: accepted while busy is low, result strobed the next cycle, busy stays low
// tick: busy from acceptance until the result is strobed
// result strobe lasts one cycle; the receiver cannot stall it; one ram read per step
// reset is synchronous: counts, pointers and time clear at once, stores are not cleared
`include "four_level_priority_dispatcher_defines.svh"

module four_level_priority_dispatcher #(
   parameter int QUEUE_DEPTH = 16,
   parameter int LEVELS      = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fpd_pkg::req_type req_data,
   output logic             rsp_strobe,
   output fpd_pkg::rsp_type rsp_data
);

   // ring index, count and level index widths
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int LW = $clog2(LEVELS);
   localparam int LVL_RAM_DEPTH = 1 << (LW + IW);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_ADM_RD  = 5'b00010,
      ST_ADM_CHK = 5'b00100,
      ST_DSP_RD  = 5'b01000,
      ST_DSP_CHK = 5'b10000
   } state_type;

   // wrap a ring pointer
   function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
      logic [IW-1:0] r;
      if (p == IW'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + IW'(1);
      end
      return r;
   endfunction

   // tail slot = (head + count) mod depth, sum stays below twice the depth
   function automatic logic [IW-1:0] tail_slot(input logic [IW-1:0] h,
                                                input logic [CW-1:0] c);
      logic [SW-1:0] s;
      s = SW'(h) + SW'(c);
      if (s >= SW'(QUEUE_DEPTH)) begin
         s = s - SW'(QUEUE_DEPTH);
      end
      return s[IW-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [IW-1:0] pend_head_ff, pend_head_in;
   logic [CW-1:0] pend_count_ff, pend_count_in;
   logic [IW-1:0] lvl_head_ff  [LEVELS];
   logic [IW-1:0] lvl_head_in  [LEVELS];
   logic [CW-1:0] lvl_count_ff [LEVELS];
   logic [CW-1:0] lvl_count_in [LEVELS];
   logic [LW-1:0] scan_ff, scan_in;
   logic [fpd_pkg::TIME_W-1:0] time_ff, time_in;

   logic             rsp_strobe_ff, rsp_strobe_in;
   fpd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // pending store ports
   logic                    pend_we;
   logic [IW-1:0]           pend_wr_addr;
   fpd_pkg::pend_entry_type pend_wr_data;
   logic                    pend_re;
   fpd_pkg::pend_entry_type pend_rd;

   // level store ports, address is {level, slot}
   logic                   lvl_we;
   logic [LW+IW-1:0]       lvl_wr_addr;
   fpd_pkg::lvl_entry_type lvl_wr_data;
   logic                   lvl_re;
   logic [LW+IW-1:0]       lvl_rd_addr;
   fpd_pkg::lvl_entry_type lvl_rd;

   // level under work: pending entry's level while admitting, scan index while dispatching
   logic [LW-1:0] adm_lv;
   logic          adm_lv_ok;
   logic [LW-1:0] cur_lv;
   logic          cur_full;
   logic          cur_empty;
   logic          scan_last;

   // shared arrival compare: pending head while admitting, level head while dispatching
   logic [fpd_pkg::TIME_W-1:0] cmp_arrival;
   logic                       eligible;

   logic [LW+1:0] scan_ext;

   fpd_ram #(
      .WIDTH ($bits(fpd_pkg::pend_entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (pend_wr_addr),
      .wr_data (pend_wr_data),
      .rd_en   (pend_re),
      .rd_addr (pend_head_ff),
      .rd_data (pend_rd)
   );

   fpd_ram #(
      .WIDTH ($bits(fpd_pkg::lvl_entry_type)),
      .DEPTH (LVL_RAM_DEPTH)
   ) u_lvl_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (lvl_wr_addr),
      .wr_data (lvl_wr_data),
      .rd_en   (lvl_re),
      .rd_addr (lvl_rd_addr),
      .rd_data (lvl_rd)
   );

   assign adm_lv    = pend_rd.priority_level[LW-1:0];
   assign adm_lv_ok = ({1'b0, pend_rd.priority_level} < (fpd_pkg::PRI_W + 1)'(LEVELS));
   assign cur_lv    = (state_ff == ST_ADM_CHK) ? adm_lv : scan_ff;
   assign cur_full  = (lvl_count_ff[cur_lv] == CW'(QUEUE_DEPTH));
   assign cur_empty = (lvl_count_ff[cur_lv] == '0);
   assign scan_last = (scan_ff == LW'(LEVELS - 1));

   assign cmp_arrival = (state_ff == ST_ADM_CHK) ? pend_rd.arrival_time : lvl_rd.arrival_time;
   assign eligible    = (cmp_arrival <= time_ff);

   // new submission lands at the pending tail
   assign pend_wr_addr = tail_slot(pend_head_ff, pend_count_ff);
   assign pend_wr_data = '{job_id:         req_data.job_id,
                           arrival_time:   req_data.arrival_time,
                           priority_level: req_data.priority_level};
   assign pend_re      = (state_ff == ST_ADM_RD) && (pend_count_ff != '0);

   // admitted entry lands at its level's tail
   assign lvl_wr_addr = {adm_lv, tail_slot(lvl_head_ff[adm_lv], lvl_count_ff[adm_lv])};
   assign lvl_wr_data = '{job_id: pend_rd.job_id, arrival_time: pend_rd.arrival_time};
   assign lvl_rd_addr = {scan_ff, lvl_head_ff[scan_ff]};
   assign lvl_re      = (state_ff == ST_DSP_RD) && !cur_empty;

   // out_level keeps the low two bits of the level number
   assign scan_ext = {2'b00, scan_ff};

   always_comb begin
      state_in      = state_ff;
      pend_head_in  = pend_head_ff;
      pend_count_in = pend_count_ff;
      lvl_head_in   = lvl_head_ff;
      lvl_count_in  = lvl_count_ff;
      scan_in       = scan_ff;
      time_in       = time_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      pend_we       = 1'b0;
      lvl_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.mode == fpd_pkg::MODE_SUBMIT) begin
                  // submit answers right away, pending full means rejected
                  rsp_strobe_in = 1'b1;
                  if (pend_count_ff == CW'(QUEUE_DEPTH)) begin
                     rsp_data_in.submit_rejected = 1'b1;
                  end else begin
                     pend_we       = 1'b1;
                     pend_count_in = pend_count_ff + CW'(1);
                  end
               end else begin
                  state_in = ST_ADM_RD;
               end
            end
         end

         ST_ADM_RD: begin
            // read the pending head, or go dispatch when pending is empty
            if (pend_count_ff == '0) begin
               scan_in  = '0;
               state_in = ST_DSP_RD;
            end else begin
               state_in = ST_ADM_CHK;
            end
         end

         ST_ADM_CHK: begin
            priority if (!eligible) begin
               // head not yet due, admission ends
               scan_in  = '0;
               state_in = ST_DSP_RD;
            end else if (!adm_lv_ok) begin
               // level out of range, drop it
               pend_head_in  = ptr_inc(pend_head_ff);
               pend_count_in = pend_count_ff - CW'(1);
               state_in      = ST_ADM_RD;
            end else if (cur_full) begin
               // target level full, entry waits at the pending head
               scan_in  = '0;
               state_in = ST_DSP_RD;
            end else begin
               lvl_we               = 1'b1;
               lvl_count_in[adm_lv] = lvl_count_ff[adm_lv] + CW'(1);
               pend_head_in         = ptr_inc(pend_head_ff);
               pend_count_in        = pend_count_ff - CW'(1);
               state_in             = ST_ADM_RD;
            end
         end

         ST_DSP_RD: begin
            // empty level is skipped without a read
            if (!cur_empty) begin
               state_in = ST_DSP_CHK;
            end else if (scan_last) begin
               rsp_strobe_in = 1'b1;
               time_in       = time_ff + fpd_pkg::TIME_W'(1);
               state_in      = ST_IDLE;
            end else begin
               scan_in = scan_ff + LW'(1);
            end
         end

         ST_DSP_CHK: begin
            if (eligible) begin
               rsp_strobe_in           = 1'b1;
               rsp_data_in.dispatched  = 1'b1;
               rsp_data_in.out_job_id  = lvl_rd.job_id;
               rsp_data_in.out_level   = scan_ext[1:0];
               lvl_head_in[scan_ff]    = ptr_inc(lvl_head_ff[scan_ff]);
               lvl_count_in[scan_ff]   = lvl_count_ff[scan_ff] - CW'(1);
               time_in                 = time_ff + fpd_pkg::TIME_W'(1);
               state_in                = ST_IDLE;
            end else if (scan_last) begin
               // nothing due on any level, time still moves on
               rsp_strobe_in = 1'b1;
               time_in       = time_ff + fpd_pkg::TIME_W'(1);
               state_in      = ST_IDLE;
            end else begin
               scan_in  = scan_ff + LW'(1);
               state_in = ST_DSP_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_head_ff  <= '0;
         pend_count_ff <= '0;
         scan_ff       <= '0;
         time_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            lvl_head_ff[i]  <= '0;
            lvl_count_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         pend_head_ff  <= pend_head_in;
         pend_count_ff <= pend_count_in;
         scan_ff       <= scan_in;
         time_ff       <= time_in;
         rsp_strobe_ff <= rsp_strobe_in;
         lvl_head_ff   <= lvl_head_in;
         lvl_count_ff  <= lvl_count_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // a tick keeps the block busy the following cycle
   `FPD_ASSERT_NEXT(a_tick_busy, start && !busy && (req_data.mode == fpd_pkg::MODE_TICK), busy)
   // a submit answers the next cycle without a dispatch
   `FPD_ASSERT_NEXT(a_submit_rsp, start && !busy && (req_data.mode == fpd_pkg::MODE_SUBMIT), rsp_strobe && !rsp_data.dispatched)
   // a level head is checked only when that level holds entries
   `FPD_ASSERT_NOW(a_chk_nonempty, state_ff == ST_DSP_CHK, lvl_count_ff[scan_ff] != '0)
   // pending check always follows its ram read
   `FPD_ASSERT_NOW(a_adm_order, state_ff == ST_ADM_CHK, $past(state_ff) == ST_ADM_RD)
   // no dispatch means zero id and level
   `FPD_ASSERT_NOW(a_idle_zero, rsp_strobe && !rsp_data.dispatched, (rsp_data.out_job_id == '0) && (rsp_data.out_level == '0))

endmodule
